// ===== rtl/core/tkt_pkg.sv =====
// shared types and sizing constants for the top-k tracker
// used by tkt_cell and top_k_tracker; no dependencies
package tkt_pkg;

  localparam int ENTRIES = 8;
  localparam int KEY_W   = 48;
  localparam int TAG_W   = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int RD_W    = (CNT_W > 3) ? CNT_W : 3;

  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // values broadcast to every cell for the item being handled
  typedef struct packed {
    logic             upd;
    logic             full;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] min_key;
  } bcast_t;

  // per-slot occupancy, derived from the fill count
  typedef struct packed {
    logic occupied;
    logic in_fill;
  } slot_t;

  // what one cell hands to the next one down the chain
  typedef struct packed {
    logic             cut;
    logic             eqmin;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } link_t;

endpackage

// ===== rtl/core/top_k_tracker.sv =====
// top level of the top-k tracker: fill count, chain of rank cells, result register
// depends on tkt_pkg and tkt_cell
//
// Keeps the largest keys seen, each with a tag, sorted by descending key with
// equal keys in arrival order. Request channel (req_valid/req_ready) carries
// func, item_key, item_tag and read_index; func offer places the key if the
// list has room or the key beats the smallest held key (the oldest entry tied
// at the minimum is dropped), func read returns the entry at read_index.
// Response channel (rsp_valid/rsp_ready) carries one result item per request.
// Every cell compares its key with the offer in parallel and the cells shift
// together when the item is placed, and the result appears in the response
// register the cycle after acceptance. One item per cycle is sustained while
// the receiver keeps taking results; when rsp_ready is low the result holds
// and req_ready drops until it is taken. Synchronous reset empties the list
// (fill count zero); no clearing pass is needed.
module top_k_tracker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic                      func,
  input  logic [tkt_pkg::KEY_W-1:0] item_key,
  input  logic [tkt_pkg::TAG_W-1:0] item_tag,
  input  logic [2:0]                read_index,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic                      accepted,
  output logic [2:0]                placed_rank,
  output logic [3:0]                fill_level,
  output logic                      entry_present,
  output logic [tkt_pkg::KEY_W-1:0] entry_key,
  output logic [tkt_pkg::TAG_W-1:0] entry_tag
);

  logic [tkt_pkg::CNT_W-1:0] count;
  logic [tkt_pkg::CNT_W-1:0] count_next;

  tkt_pkg::bcast_t bc;
  tkt_pkg::slot_t  slot  [tkt_pkg::ENTRIES];
  tkt_pkg::link_t  link  [tkt_pkg::ENTRIES];
  tkt_pkg::link_t  prev  [tkt_pkg::ENTRIES];
  logic [tkt_pkg::ENTRIES-1:0] first;
  logic [tkt_pkg::ENTRIES-1:0] rd_sel;

  logic                      take;
  logic                      full;
  logic                      place;
  logic [tkt_pkg::IDX_W-1:0] pos;
  logic                      present;
  logic [tkt_pkg::KEY_W-1:0] rd_key;
  logic [tkt_pkg::TAG_W-1:0] rd_tag;

  assign req_ready = !rsp_valid || rsp_ready;
  assign take      = req_valid && req_ready;
  assign full      = (count == tkt_pkg::CNT_W'(tkt_pkg::ENTRIES));
  // the last rank holds the minimum once the list is full
  assign place     = (func == tkt_pkg::FUNC_OFFER) &&
                     (!full || (item_key > link[tkt_pkg::ENTRIES-1].key));

  assign bc.upd     = take && place;
  assign bc.full    = full;
  assign bc.key     = item_key;
  assign bc.tag     = item_tag;
  assign bc.min_key = link[tkt_pkg::ENTRIES-1].key;

  for (genvar i = 0; i < tkt_pkg::ENTRIES; i++) begin : g_cell
    assign slot[i].occupied = (tkt_pkg::CNT_W'(i) < count);
    assign slot[i].in_fill  = (tkt_pkg::CNT_W'(i) <= count);
    assign rd_sel[i]        = (tkt_pkg::RD_W'(read_index) == tkt_pkg::RD_W'(i));

    if (i == 0) begin : g_head
      assign prev[i] = '0;
    end else begin : g_link
      assign prev[i] = link[i-1];
    end

    tkt_cell u_cell (
      .clk   (clk),
      .bc    (bc),
      .slot  (slot[i]),
      .prev  (prev[i]),
      .link  (link[i]),
      .first (first[i])
    );
  end

  // encode the insertion point and select the read entry
  always_comb begin
    pos    = '0;
    rd_key = '0;
    rd_tag = '0;
    for (int i = 0; i < tkt_pkg::ENTRIES; i++) begin
      if (first[i]) begin
        pos = pos | tkt_pkg::IDX_W'(i);
      end
      if (rd_sel[i]) begin
        rd_key = rd_key | link[i].key;
        rd_tag = rd_tag | link[i].tag;
      end
    end
  end

  assign present = (func == tkt_pkg::FUNC_READ) &&
                   (tkt_pkg::RD_W'(read_index) < tkt_pkg::RD_W'(count));

  always_comb begin
    count_next = count;
    if (take && place && !full) begin
      count_next = count + tkt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accepted      <= place;
      placed_rank   <= place ? 3'(pos) : 3'd0;
      fill_level    <= 4'(count_next);
      entry_present <= present;
      entry_key     <= present ? rd_key : '0;
      entry_tag     <= present ? rd_tag : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tkt_pkg::CNT_W'(tkt_pkg::ENTRIES))
    else $error("fill count beyond capacity");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (take && place && !full) |=> (count == $past(count) + tkt_pkg::CNT_W'(1)))
    else $error("placed item did not grow the fill count");

  a_read_keeps: assert property (@(posedge clk) disable iff (rst)
    (take && func == tkt_pkg::FUNC_READ) |=> $stable(count))
    else $error("read item changed the fill count");

  a_one_first: assert property (@(posedge clk) disable iff (rst)
    (take && place) |-> $onehot(first))
    else $error("placed item has no single insertion point");

endmodule

// ===== rtl/core/tkt_cell.sv =====
// one rank slot of the top-k tracker: holds a key and tag, compares against the offer
// and either keeps its entry, takes the new item or takes its upper neighbor's entry
// depends on tkt_pkg
module tkt_cell (
  input  logic           clk,
  input  tkt_pkg::bcast_t bc,
  input  tkt_pkg::slot_t  slot,
  input  tkt_pkg::link_t  prev,
  output tkt_pkg::link_t  link,
  output logic            first
);

  logic [tkt_pkg::KEY_W-1:0] key;
  logic [tkt_pkg::TAG_W-1:0] tag;
  logic                      cut;
  logic                      eqmin;
  logic                      region;

  // cut marks the suffix of ranks holding a smaller key (or empty)
  assign cut    = !slot.occupied || (key < bc.key);
  assign eqmin  = slot.occupied && (key == bc.min_key);
  // ranks that may shift: up to the fill when not full, up to the first minimum tie when full
  assign region = bc.full ? !prev.eqmin : slot.in_fill;
  assign first  = cut && !prev.cut;

  always_ff @(posedge clk) begin
    if (bc.upd) begin
      if (first) begin
        key <= bc.key;
        tag <= bc.tag;
      end else if (cut && region) begin
        key <= prev.key;
        tag <= prev.tag;
      end
    end
  end

  assign link.cut   = cut;
  assign link.eqmin = eqmin;
  assign link.key   = key;
  assign link.tag   = tag;

endmodule
